>>> rtl/firlp_pkg.sv
// Shared types, constants and tap ROM of the FIR low-pass filter.
package firlp_pkg;

    // Filter dimensions.
    localparam int TAPS       = 71;
    localparam int COEF_WIDTH = 16;
    localparam int ROM_LEN    = 71;

    // Derived widths.
    localparam int SMP_W  = 16;
    localparam int IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PROD_W = SMP_W + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + IDX_W;
    localparam int SCL_W  = ACC_W - COEF_WIDTH + 1;

    // Saturation limits and rounding offset for the final scaling.
    localparam int      SMP_MAX  = 32767;
    localparam int      SMP_MIN  = -32768;
    localparam longint  SCALE_M1 = (longint'(1) <<< (COEF_WIDTH - 1)) - 1;

    // Shift amounts that take a Q1.15 ROM tap to COEF_WIDTH bits.
    localparam int COEF_UP = (COEF_WIDTH >= 16) ? COEF_WIDTH - 16 : 0;
    localparam int COEF_DN = (COEF_WIDTH < 16) ? 16 - COEF_WIDTH : 0;

    typedef logic signed [SMP_W-1:0]      t_sample;
    typedef logic signed [COEF_WIDTH-1:0] t_coef;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [ACC_W-1:0]      t_acc;
    typedef logic signed [SCL_W-1:0]      t_scaled;
    typedef logic [IDX_W-1:0]             t_idx;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FIN
    } t_state;

    // Controls from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } t_mac_ctrl;

    // Symmetric low-pass taps, signed Q1.15.
    localparam int TAP_ROM [ROM_LEN] = '{
          188,   244,   -38,  -100,   -85,   146,   123,   -77,  -209,     0,
          237,   131,  -218,  -264,   117,   375,    55,  -415,  -282,   347,
          518,  -145,  -702,  -194,   759,   647,  -610, -1163,   162,  1677,
          735, -2113, -2592,  2406, 10122, 13875, 10122,  2406, -2592, -2113,
          735,  1677,   162, -1163,  -610,   647,   759,  -194,  -702,  -145,
          518,   347,  -282,  -415,    55,   375,   117,  -264,  -218,   131,
          237,     0,  -209,   -77,   123,   146,   -85,  -100,   -38,   244,
          188
    };

    // Tap at COEF_WIDTH bits; positions beyond the ROM weigh zero.
    function automatic t_coef tap_coef(input t_idx idx);
        int v;
        v = 0;
        if (int'(idx) < ROM_LEN) begin
            v = TAP_ROM[idx] <<< COEF_UP;
            if (v < 0) begin
                v = -((-v) >>> COEF_DN);
            end else begin
                v = v >>> COEF_DN;
            end
        end
        return t_coef'(v);
    endfunction

endpackage

>>> rtl/firlp_mac.sv
// Shared multiply-accumulate unit with final scaling and saturation.
module firlp_mac (
    input  logic                i_clk,
    input  firlp_pkg::t_mac_ctrl i_ctrl,
    input  firlp_pkg::t_sample  i_sample,
    input  firlp_pkg::t_coef    i_coef,
    output firlp_pkg::t_sample  o_result
);
    import firlp_pkg::*;

    t_prod   r_prod;
    t_acc    r_acc;
    t_acc    bias;
    t_acc    biased;
    t_scaled scaled;

    // Product register, then accumulator at full precision.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_sample * i_coef;
        end
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en) begin
            r_acc <= r_acc + t_acc'(r_prod);
        end
    end

    // Scale down with truncation toward zero, then saturate to 16 bits.
    always_comb begin
        bias   = r_acc[ACC_W-1] ? t_acc'(SCALE_M1) : '0;
        biased = r_acc + bias;
        scaled = t_scaled'(biased >>> (COEF_WIDTH - 1));
        if (scaled > t_scaled'(SMP_MAX)) begin
            o_result = t_sample'(SMP_MAX);
        end else if (scaled < t_scaled'(SMP_MIN)) begin
            o_result = t_sample'(SMP_MIN);
        end else begin
            o_result = t_sample'(scaled);
        end
    end

endmodule

>>> rtl/fir_lowpass_filter.sv
// Top level of the 71-tap FIR low-pass filter with its delay-line memory and sequencer.
// Each accepted input word is written into a circular delay line of TAPS entries, and
// one shared multiplier then walks the taps, one per cycle, newest sample first. An item
// passes through these steps from acceptance to a loaded result: acceptance, memory reads
// of the taps feeding the multiplier, a drain of the read, multiply and accumulate
// stages, and scaling and saturation as the result is loaded. The single multiplier and
// the one read port of the delay line mean the taps are read one at a time. The delay
// line reads as zero at every position until written, by way of per-entry valid flags
// that reset clears at once, so no clearing pass is needed. A finished word waits in the
// output register and the next input word is taken while it waits.
module fir_lowpass_filter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  firlp_pkg::t_sample i_sample_in,
    output logic               o_valid,
    input  logic               i_ready,
    output firlp_pkg::t_sample o_filtered_out
);
    import firlp_pkg::*;

    localparam t_idx LAST = t_idx'(TAPS - 1);

    t_state    r_state;
    t_state    n_state;
    t_sample   r_mem [TAPS];
    logic [TAPS-1:0] r_valid;
    t_idx      r_wptr;
    t_idx      r_raddr;
    t_idx      r_issue;
    t_sample   r_rd_data;
    t_coef     r_coef;
    logic      r_v1;
    logic      r_v2;
    logic      r_out_valid;
    t_sample   r_out_data;
    logic      accept;
    logic      issue;
    logic      load_out;
    t_mac_ctrl mac_ctrl;
    t_sample   mac_result;

    assign o_ready        = (r_state == ST_IDLE);
    assign accept         = i_valid && o_ready;
    assign o_valid        = r_out_valid;
    assign o_filtered_out = r_out_data;

    // Next state and sequencer controls.
    always_comb begin
        n_state        = r_state;
        issue          = 1'b0;
        load_out       = 1'b0;
        mac_ctrl.clear = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    mac_ctrl.clear = 1'b1;
                    n_state        = ST_RUN;
                end
            end
            ST_RUN: begin
                issue = 1'b1;
                if (r_issue == LAST) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        mac_ctrl.mul_en = r_v1;
        mac_ctrl.acc_en = r_v2;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_wptr      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            if (accept) begin
                r_valid[r_wptr] <= 1'b1;
                r_wptr          <= (r_wptr == LAST) ? '0 : r_wptr + t_idx'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Delay-line memory, read walk and coefficient fetch.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_wptr] <= i_sample_in;
            r_raddr       <= r_wptr;
            r_issue       <= '0;
        end
        if (issue) begin
            r_rd_data <= r_valid[r_raddr] ? r_mem[r_raddr] : '0;
            r_coef    <= tap_coef(r_issue);
            r_raddr   <= (r_raddr == '0) ? LAST : r_raddr - t_idx'(1);
            r_issue   <= r_issue + t_idx'(1);
        end
        if (load_out) begin
            r_out_data <= mac_result;
        end
    end

    firlp_mac u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_sample (r_rd_data),
        .i_coef   (r_coef),
        .o_result (mac_result)
    );

endmodule

>>> rtl/firlp_checker.sv
// Port-level checker for the FIR low-pass filter and its bind to the top level.
module firlp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input firlp_pkg::t_sample i_sample_in,
    input logic               o_valid,
    input logic               i_ready,
    input firlp_pkg::t_sample o_filtered_out
);
    import firlp_pkg::*;

    // A stalled output word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_filtered_out))
        else $error("output word changed or dropped while stalled");

    // The block is busy in the cycle after it takes a word.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready stayed high after a word was taken");

    // A new result only appears at the end of a run, never while idle.
    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result appeared without a filter run");

    // No result can be ready in the cycle straight after taking a word.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !$rose(o_valid))
        else $error("result appeared too early after a word was taken");

endmodule

bind fir_lowpass_filter firlp_checker u_firlp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_sample_in    (i_sample_in),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_filtered_out (o_filtered_out)
);

>>> verif/tb.sv
// Self-checking testbench for the 71-tap FIR low-pass filter with random flow control.
`timescale 1ns / 1ps

module tb;
    import firlp_pkg::*;

    // Tracks the delay line, predicts each filtered word and checks what comes out.
    class lowpass_tracker;
        t_sample history [TAPS];
        longint  coef [TAPS];
        longint  out_weight;
        t_sample pending_outputs [$];
        int      fail_count;

        function new();
            longint v;
            for (int i = 0; i < TAPS; i++) begin
                history[i] = '0;
                // Positions past the end of the tap table weigh nothing.
                v = 0;
                if (i < ROM_LEN) begin
                    v = TAP_ROM[i];
                    if (COEF_WIDTH >= 16) begin
                        v = v * (longint'(1) <<< (COEF_WIDTH - 16));
                    end else begin
                        v = v / (longint'(1) <<< (16 - COEF_WIDTH));
                    end
                end
                coef[i] = v;
            end
            out_weight = longint'(1) <<< (COEF_WIDTH - 1);
            fail_count = 0;
        endfunction

        // Shifts one sample in and works out the filtered word it gives.
        function t_sample filter_next(t_sample s);
            longint acc;
            longint y;
            for (int i = TAPS - 1; i > 0; i--) begin
                history[i] = history[i - 1];
            end
            history[0] = s;
            acc = 0;
            for (int i = 0; i < TAPS; i++) begin
                acc += coef[i] * longint'(history[i]);
            end
            // Division truncates toward zero; then clamp to the 16-bit range.
            y = acc / out_weight;
            if (y > SMP_MAX) begin
                y = SMP_MAX;
            end
            if (y < SMP_MIN) begin
                y = SMP_MIN;
            end
            return t_sample'(y);
        endfunction

        function void take_sample(t_sample s);
            pending_outputs.push_back(filter_next(s));
        endfunction

        function void match_output(t_sample got);
            t_sample want;
            if (pending_outputs.size() == 0) begin
                $error("filtered_out: no word expected, got %0d", got);
                fail_count++;
                return;
            end
            want = pending_outputs.pop_front();
            if (got !== want) begin
                $error("filtered_out: expected %0d, got %0d", want, got);
                fail_count++;
            end
        endfunction

        function int outstanding();
            return pending_outputs.size();
        endfunction
    endclass

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_valid     = 1'b0;
    t_sample i_sample_in = '0;
    logic    i_ready     = 1'b0;
    logic    o_ready;
    logic    o_valid;
    t_sample o_filtered_out;

    lowpass_tracker tracker = new();
    int burst_left = 0;
    int words_sent = 0;

    fir_lowpass_filter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_in    (i_sample_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_filtered_out (o_filtered_out)
    );

    always #5 i_clk = ~i_clk;

    // Offers one word, with bursts of random length and random gaps between them.
    task automatic send_word(input t_sample v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_sample_in <= v;
        do @(posedge i_clk); while (!o_ready);
        tracker.take_sample(v);
        words_sent++;
    endtask

    // One stretch of random stimulus, shaped to reach saturation and rounding.
    task automatic random_segment();
        int kind;
        int len;
        int amp;
        int tap;
        bit neg;
        t_sample v;
        kind = $urandom_range(0, 9);
        neg  = $urandom_range(0, 1);
        amp  = $urandom_range(30000, 32768);
        case (kind)
            0, 1, 2, 3: begin
                len = $urandom_range(10, 60);
                repeat (len) send_word(t_sample'($urandom()));
            end
            4: begin
                // Small values show whether negative sums are cut toward zero.
                len = $urandom_range(20, 80);
                repeat (len) send_word(t_sample'($urandom_range(0, 8) - 4));
            end
            5: begin
                len = $urandom_range(20, 90);
                v = neg ? t_sample'(SMP_MIN) : t_sample'(SMP_MAX);
                repeat (len) send_word(v);
            end
            6, 7: begin
                // Full-scale samples signed like the taps drive the sum past full scale.
                for (int j = 0; j < TAPS; j++) begin
                    tap = (TAPS - 1 - j < ROM_LEN) ? TAP_ROM[TAPS - 1 - j] : 0;
                    if (tap == 0) begin
                        v = t_sample'($urandom());
                    end else if ((tap > 0) != neg) begin
                        v = t_sample'((amp > SMP_MAX) ? SMP_MAX : amp);
                    end else begin
                        v = t_sample'(-amp);
                    end
                    send_word(v);
                end
            end
            8: begin
                len = $urandom_range(20, 71);
                for (int j = 0; j < len; j++) begin
                    send_word(((j % 2) == 0) ? t_sample'(SMP_MAX) : t_sample'(SMP_MIN));
                end
            end
            default: begin
                send_word(t_sample'($urandom()));
                repeat ($urandom_range(TAPS, TAPS + 10)) send_word('0);
            end
        endcase
    endtask

    // Output side: check every word taken, and stall on a rotating pattern.
    logic [31:0] stall_pattern = '1;
    int          pattern_age   = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tracker.match_output(o_filtered_out);
        end
        if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pattern = '1;
                1:       stall_pattern = $urandom() & $urandom();
                default: stall_pattern = $urandom();
            endcase
            pattern_age = 64;
        end
        pattern_age--;
        i_ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
    end

    // Main sequence: reset, directed words, random segments, drain.
    initial begin
        t_sample directed [$];
        directed = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF,
                     16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh5555,
                     16'shAAAA, 16'sh0100, 16'shFF00, 16'sh0064, 16'shFF9C,
                     16'sh0000, 16'sh0000, 16'sh0002, 16'shFFFE, 16'sh03E8,
                     16'shFC18, 16'sh0000};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_word(directed[k]);
        end
        while (words_sent < 1300) begin
            random_segment();
        end
        i_valid <= 1'b0;

        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (tracker.fail_count == 0 && tracker.outstanding() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
